@@ design/dlpbe_pkg.sv @@
// dlpbe_pkg: shared types and constants for the dual led pulse/blink engine
// no dependencies; imported by every module of the block

package dlpbe_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned RAMP_W   = 7;
    localparam int unsigned TICK_W   = 32;
    localparam int unsigned PERIOD_W = 32;

    localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 32'd1000;
    localparam logic [RAMP_W-1:0]   RAMP_TOP           = 7'h7F;
    localparam logic [LEVEL_W-1:0]  LEVEL_FULL         = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_UPDATE     = 2'd0,
        FUNC_SET_PULSES = 2'd1,
        FUNC_SET_FIXED  = 2'd2,
        FUNC_BLINK      = 2'd3
    } t_func;

    localparam logic [1:0] RX_MODE_OFF   = 2'd0;
    localparam logic [1:0] RX_MODE_BLINK = 2'd1;
    localparam logic [1:0] RX_MODE_FIXED = 2'd2;

    localparam logic TX_MODE_OFF   = 1'b0;
    localparam logic TX_MODE_FIXED = 1'b1;

    localparam logic CHAN_RX = 1'b0;

    typedef struct packed {
        logic [RAMP_W-1:0]  ramp;
        logic               falling;
        logic [LEVEL_W-1:0] pulses;
    } t_ramp_st;

endpackage

@@ design/dlpbe_in_if.sv @@
// dlpbe_in_if: valid/ready channel carrying one command beat
// depends on dlpbe_pkg for field widths

interface dlpbe_in_if import dlpbe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [1:0]         func;
    logic               channel;
    logic [LEVEL_W-1:0] value;
    logic [TICK_W-1:0]  tick_now;

    modport source (output valid, func, channel, value, tick_now, input ready);
    modport sink   (input valid, func, channel, value, tick_now, output ready);
endinterface

@@ design/dlpbe_out_if.sv @@
// dlpbe_out_if: valid/ready channel carrying one pair of led levels per beat
// depends on dlpbe_pkg for field widths

interface dlpbe_out_if import dlpbe_pkg::*;;
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] rx_level;
    logic [LEVEL_W-1:0] tx_level;

    modport source (output valid, rx_level, tx_level, input ready);
    modport sink   (input valid, rx_level, tx_level, output ready);
endinterface

@@ design/dual_led_pulse_blink_engine_top.sv @@
// dual_led_pulse_blink_engine_top: command register, state update and level output register
// depends on dlpbe_pkg, dlpbe_in_if, dlpbe_out_if and dlpbe_ramp

// Takes one command beat per clock while not stalled and returns one beat of both led
// levels per command, through an input register, then the state update and result
// register. Throughput is one beat per cycle while the output is not stalled; the input
// register can take one new command while a result waits, and stalls once it holds one.
// TIME_WIDTH sets how many low bits of tick_now take part in blink timing.

module dual_led_pulse_blink_engine_top import dlpbe_pkg::*; #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [PERIOD_W-1:0] i_cfg_wdata,
    dlpbe_in_if.sink            i_in,
    dlpbe_out_if.source         o_out
);

    logic                r_blink_period;
    logic [PERIOD_W-1:0] r_period;

    logic               r_in_valid;
    logic [1:0]         r_in_func;
    logic               r_in_channel;
    logic [LEVEL_W-1:0] r_in_value;
    logic [TICK_W-1:0]  r_in_tick;

    logic r_out_valid;
    logic w_adv;

    t_ramp_st             r_rx_st, n_rx_st, w_rx_step;
    t_ramp_st             r_tx_st, n_tx_st, w_tx_step;
    logic [1:0]           r_rx_mode, n_rx_mode;
    logic                 r_tx_mode, n_tx_mode;
    logic [LEVEL_W-1:0]   r_rx_fixed, n_rx_fixed;
    logic [LEVEL_W-1:0]   r_tx_fixed, n_tx_fixed;
    logic [TIME_WIDTH-1:0] r_rx_start, n_rx_start;
    logic [LEVEL_W-1:0]   r_rx_out, n_rx_out;
    logic [LEVEL_W-1:0]   r_tx_out, n_tx_out;

    logic [63:0]           w_tick64;
    logic [TIME_WIDTH-1:0] w_now;
    logic [TIME_WIDTH-1:0] w_diff;
    logic                  w_due;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period       <= BLINK_PERIOD_RESET;
            r_blink_period <= 1'b0;
        end else begin
            r_blink_period <= 1'b0;
            if (i_cfg_we) begin
                r_period       <= i_cfg_wdata;
                r_blink_period <= 1'b1;
            end
        end
    end

    assign w_adv      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || w_adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_func    <= i_in.func;
            r_in_channel <= i_in.channel;
            r_in_value   <= i_in.value;
            r_in_tick    <= i_in.tick_now;
        end
    end

    dlpbe_ramp u_rx_ramp (.i_cur(r_rx_st), .o_nxt(w_rx_step));
    dlpbe_ramp u_tx_ramp (.i_cur(r_tx_st), .o_nxt(w_tx_step));

    assign w_tick64 = 64'(r_in_tick);
    assign w_now    = w_tick64[TIME_WIDTH-1:0];
    assign w_diff   = w_now - r_rx_start;
    assign w_due    = 64'(w_diff) > 64'(r_period);

    always_comb begin
        n_rx_st    = r_rx_st;
        n_tx_st    = r_tx_st;
        n_rx_mode  = r_rx_mode;
        n_tx_mode  = r_tx_mode;
        n_rx_fixed = r_rx_fixed;
        n_tx_fixed = r_tx_fixed;
        n_rx_start = r_rx_start;
        n_rx_out   = r_rx_out;
        n_tx_out   = r_tx_out;
        case (t_func'(r_in_func))
            FUNC_UPDATE: begin
                if (r_rx_st.pulses != '0) begin
                    n_rx_st  = w_rx_step;
                    n_rx_out = {1'b0, w_rx_step.ramp};
                end else if (r_rx_mode == RX_MODE_FIXED) begin
                    n_rx_out = r_rx_fixed;
                end else if (r_rx_mode == RX_MODE_BLINK) begin
                    if (w_due) begin
                        n_rx_fixed = LEVEL_FULL - r_rx_fixed;
                        n_rx_out   = LEVEL_FULL - r_rx_fixed;
                        n_rx_start = w_now;
                    end
                end else begin
                    n_rx_out = '0;
                end
                if (r_tx_st.pulses != '0) begin
                    n_tx_st  = w_tx_step;
                    n_tx_out = {1'b0, w_tx_step.ramp};
                end else if (r_tx_mode == TX_MODE_FIXED) begin
                    n_tx_out = r_tx_fixed;
                end else begin
                    n_tx_out = '0;
                end
            end
            FUNC_SET_PULSES: begin
                if (r_in_channel == CHAN_RX) begin
                    n_rx_st.pulses = r_in_value;
                end else begin
                    n_tx_st.pulses = r_in_value;
                end
            end
            FUNC_SET_FIXED: begin
                if (r_in_channel == CHAN_RX) begin
                    n_rx_mode  = RX_MODE_FIXED;
                    n_rx_fixed = r_in_value;
                end else begin
                    n_tx_mode  = TX_MODE_FIXED;
                    n_tx_fixed = r_in_value;
                end
            end
            FUNC_BLINK: begin
                if (r_in_channel == CHAN_RX) begin
                    n_rx_mode  = RX_MODE_BLINK;
                    n_rx_fixed = LEVEL_FULL;
                    n_rx_out   = LEVEL_FULL;
                    n_rx_start = w_now;
                end
            end
            default: begin
            end
        endcase
    end

    // channel state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_rx_st     <= '0;
            r_tx_st     <= '0;
            r_rx_mode   <= RX_MODE_OFF;
            r_tx_mode   <= TX_MODE_OFF;
            r_rx_fixed  <= '0;
            r_tx_fixed  <= '0;
            r_rx_start  <= '0;
            r_rx_out    <= '0;
            r_tx_out    <= '0;
        end else begin
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_rx_st     <= n_rx_st;
                r_tx_st     <= n_tx_st;
                r_rx_mode   <= n_rx_mode;
                r_tx_mode   <= n_tx_mode;
                r_rx_fixed  <= n_rx_fixed;
                r_tx_fixed  <= n_tx_fixed;
                r_rx_start  <= n_rx_start;
                r_rx_out    <= n_rx_out;
                r_tx_out    <= n_tx_out;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.rx_level = r_rx_out;
    assign o_out.tx_level = r_tx_out;

    // ramp direction and position stay consistent
    a_rx_ramp_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rx_st.falling ? (r_rx_st.ramp != '0) : (r_rx_st.ramp != RAMP_TOP)))
        else $error("rx ramp direction inconsistent with position");

    // blink start shows full level on the next beat
    a_blink_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && (r_in_func == FUNC_BLINK) && (r_in_channel == CHAN_RX))
        |=> (o_out.valid && (o_out.rx_level == LEVEL_FULL)))
        else $error("blink start did not drive full rx level");

    // a held command moves on once the result register is free
    a_in_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_out_valid) |=> r_out_valid)
        else $error("held command beat not passed to result register");

    // a config write is taken as written
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_blink_period |-> (r_period == $past(i_cfg_wdata)))
        else $error("blink period write lost");

endmodule

@@ design/dlpbe_ramp.sv @@
// dlpbe_ramp: one step of the triangular pulse ramp for a single led channel
// depends on dlpbe_pkg (t_ramp_st, RAMP_TOP)

module dlpbe_ramp import dlpbe_pkg::*; (
    input  t_ramp_st i_cur,
    output t_ramp_st o_nxt
);

    logic [RAMP_W-1:0] w_ramp;

    always_comb begin
        w_ramp = i_cur.falling ? (i_cur.ramp - 1'b1) : (i_cur.ramp + 1'b1);
        o_nxt  = i_cur;
        o_nxt.ramp = w_ramp;
        if (w_ramp == RAMP_TOP) begin
            o_nxt.falling = 1'b1;
        end else if (w_ramp == '0) begin
            o_nxt.falling = 1'b0;
            o_nxt.pulses  = i_cur.pulses - 1'b1;
        end
    end

endmodule
